[design/shelf_rect_packer_macros.svh]
// Assertion macros for the shelf rectangle packer.
// Included by the top level; no other dependencies.
`ifndef SHELF_RECT_PACKER_MACROS_SVH
`define SHELF_RECT_PACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srp_pkg.sv]
// Shared types and constants for the shelf rectangle packer.
// No dependencies.
package srp_pkg;

  localparam int DIM_W  = 13;
  localparam int RECT_W = 12;
  localparam int PAD_W  = 4;
  localparam int SUM_W  = 14;
  localparam int TOP_W  = 15;

  typedef enum logic [0:0] {
    CMD_PLACE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ATLAS_WIDTH  = 2'd0,
    REG_ATLAS_HEIGHT = 2'd1,
    REG_PADDING      = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_DECIDE
  } fsm_t;

  typedef struct packed {
    logic [DIM_W-1:0] cursor;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] height;
  } shelf_t;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] cursor;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] height;
    logic [SUM_W-1:0] base;
  } fit_t;

endpackage

[design/srp_if.sv]
// Request and response channel interfaces for the shelf rectangle packer.
// Depends on srp_pkg.
interface srp_req_if;
  logic                                valid;
  logic                                ready;
  srp_pkg::cmd_t                       cmd;
  logic [srp_pkg::RECT_W-1:0]          rect_width;
  logic [srp_pkg::RECT_W-1:0]          rect_height;

  modport source (output valid, output cmd, output rect_width, output rect_height,
                  input ready);
  modport sink (input valid, input cmd, input rect_width, input rect_height,
                output ready);
endinterface

interface srp_rsp_if;
  logic                       valid;
  logic                       ready;
  srp_pkg::status_t           status;
  logic [srp_pkg::RECT_W-1:0] pos_x;
  logic [srp_pkg::RECT_W-1:0] pos_y;

  modport source (output valid, output status, output pos_x, output pos_y,
                  input ready);
  modport sink (input valid, input status, input pos_x, input pos_y,
                output ready);
endinterface

[design/srp_shelf_mem.sv]
// Shelf table storage: one write port, one registered read port.
// Depends on srp_pkg.
module srp_shelf_mem #(
  parameter int DEPTH = 64,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  srp_pkg::shelf_t   wdata,
  input  logic              re,
  input  logic [IDX_W-1:0]  raddr,
  output srp_pkg::shelf_t   rdata
);

  srp_pkg::shelf_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/srp_fit_unit.sv]
// Best-height fit compare unit: checks one shelf per cycle and keeps the best.
// Depends on srp_pkg.
module srp_fit_unit #(
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        ev_valid,
  input  logic                        ev_last,
  input  logic [IDX_W-1:0]            ev_idx,
  input  srp_pkg::shelf_t             entry,
  input  logic [srp_pkg::DIM_W-1:0]   w_pad,
  input  logic [srp_pkg::DIM_W-1:0]   h_pad,
  input  logic [srp_pkg::DIM_W-1:0]   atlas_width,
  output srp_pkg::fit_t               fit,
  output logic [IDX_W-1:0]            best_idx
);

  logic [srp_pkg::SUM_W-1:0] end_x;
  logic                      fits;
  logic                      better;

  always_comb begin
    end_x  = srp_pkg::SUM_W'(entry.cursor) + srp_pkg::SUM_W'(w_pad);
    fits   = (entry.height >= h_pad) && (end_x <= srp_pkg::SUM_W'(atlas_width));
    better = fits && (!fit.found || (entry.height < fit.height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit.found <= 1'b0;
    end else if (start) begin
      fit.found <= 1'b0;
    end else if (ev_valid) begin
      if (better) begin
        fit.found  <= 1'b1;
        fit.cursor <= entry.cursor;
        fit.top    <= entry.top;
        fit.height <= entry.height;
        best_idx   <= ev_idx;
      end
      if (ev_last) begin
        fit.base <= srp_pkg::SUM_W'(entry.top) + srp_pkg::SUM_W'(entry.height);
      end
    end
  end

endmodule

[design/shelf_rect_packer.sv]
// Shelf rectangle packer: places rectangles in an atlas with best-height fit.
// Depends on srp_pkg, srp_if, srp_shelf_mem, srp_fit_unit.
//
// Channels: req carries cmd, rect_width and rect_height; rsp returns status,
// pos_x and pos_y, one response per request, in order. Both use valid/ready,
// a transaction moves when both are high at a rising edge. The user must
// write the registers (cfg_write, cfg_index, cfg_data) only while the block
// is idle; the block itself does not enforce this.
//
// Sequence: a place request with shelves stored steps through scan (one read
// per stored shelf on the shelf table's single read port), drain and decide,
// which loads the response register; with no shelves stored, and for clear
// and zero-size requests, it goes straight to decide, then back to idle.
//
// Reset empties the shelf table (count only; entries are rewritten before
// they are read) and loads the register defaults. When rsp stalls, the
// response register holds and the next request is taken, but its result
// waits in the decide step until the response register frees.
`include "shelf_rect_packer_macros.svh"

module shelf_rect_packer #(
  parameter int MAX_SHELVES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [srp_pkg::DIM_W-1:0]   cfg_data,
  srp_req_if.sink                     req,
  srp_rsp_if.source                   rsp
);

  localparam int IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W = $clog2(MAX_SHELVES + 1);

  logic [srp_pkg::DIM_W-1:0] atlas_width;
  logic [srp_pkg::DIM_W-1:0] atlas_height;
  logic [srp_pkg::PAD_W-1:0] padding;

  srp_pkg::fsm_t             state, state_next;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_m1;
  logic [IDX_W-1:0]          last_idx;
  logic [IDX_W-1:0]          scan_addr;
  logic                      rd_valid;
  logic                      rd_last;
  logic [IDX_W-1:0]          rd_idx;
  logic                      op_clear;
  logic                      op_zero;
  logic [srp_pkg::DIM_W-1:0] w_pad;
  logic [srp_pkg::DIM_W-1:0] h_pad;

  logic                       out_valid;
  srp_pkg::status_t           out_status;
  logic [srp_pkg::RECT_W-1:0] out_x;
  logic [srp_pkg::RECT_W-1:0] out_y;

  logic                       req_fire;
  logic                       out_free;
  logic                       out_load;
  logic                       scan_end;
  logic                       rd_en;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  srp_pkg::shelf_t            mem_wdata;
  srp_pkg::shelf_t            mem_rdata;
  srp_pkg::fit_t              fit;
  logic [IDX_W-1:0]           best_idx;
  logic [srp_pkg::SUM_W-1:0]  new_base;
  logic                       no_room;
  logic                       table_full;
  logic                       count_clear;
  logic                       count_inc;
  srp_pkg::status_t           res_status;
  logic [srp_pkg::RECT_W-1:0] res_x;
  logic [srp_pkg::RECT_W-1:0] res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= srp_pkg::DIM_W'(512);
      atlas_height <= srp_pkg::DIM_W'(512);
      padding      <= srp_pkg::PAD_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        srp_pkg::REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        srp_pkg::REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        srp_pkg::REG_PADDING:      padding      <= cfg_data[srp_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = (state == srp_pkg::FSM_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign count_m1  = count - CNT_W'(1);
  assign last_idx  = count_m1[IDX_W-1:0];
  assign scan_end  = (scan_addr == last_idx);

  srp_shelf_mem #(
    .DEPTH (MAX_SHELVES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  srp_fit_unit #(
    .IDX_W (IDX_W)
  ) u_fit (
    .clk         (clk),
    .rst         (rst),
    .start       (req_fire),
    .ev_valid    (rd_valid),
    .ev_last     (rd_last),
    .ev_idx      (rd_idx),
    .entry       (mem_rdata),
    .w_pad       (w_pad),
    .h_pad       (h_pad),
    .atlas_width (atlas_width),
    .fit         (fit),
    .best_idx    (best_idx)
  );

  always_comb begin
    new_base   = (count == '0) ? '0 : fit.base;
    no_room    = (w_pad > atlas_width) ||
                 ((srp_pkg::TOP_W'(new_base) + srp_pkg::TOP_W'(h_pad)) >
                  srp_pkg::TOP_W'(atlas_height));
    table_full = (count >= CNT_W'(MAX_SHELVES));
  end

  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = best_idx;
    mem_wdata   = '{cursor: fit.cursor + w_pad, top: fit.top, height: fit.height};
    count_clear = 1'b0;
    count_inc   = 1'b0;
    out_load    = 1'b0;
    res_status  = srp_pkg::ST_OK;
    res_x       = '0;
    res_y       = '0;
    case (state)
      srp_pkg::FSM_IDLE: begin
        if (req_fire) begin
          if ((req.cmd == srp_pkg::CMD_CLEAR) || (req.rect_width == '0) ||
              (req.rect_height == '0) || (count == '0)) begin
            state_next = srp_pkg::FSM_DECIDE;
          end else begin
            state_next = srp_pkg::FSM_SCAN;
          end
        end
      end
      srp_pkg::FSM_SCAN: begin
        rd_en = 1'b1;
        if (scan_end) begin
          state_next = srp_pkg::FSM_DRAIN;
        end
      end
      srp_pkg::FSM_DRAIN: begin
        state_next = srp_pkg::FSM_DECIDE;
      end
      srp_pkg::FSM_DECIDE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = srp_pkg::FSM_IDLE;
          if (op_clear) begin
            count_clear = 1'b1;
          end else if (op_zero) begin
            res_status = srp_pkg::ST_OK;
          end else if (fit.found) begin
            mem_we = 1'b1;
            res_x  = fit.cursor[srp_pkg::RECT_W-1:0];
            res_y  = fit.top[srp_pkg::RECT_W-1:0];
          end else if (no_room) begin
            res_status = srp_pkg::ST_NO_ROOM;
          end else if (table_full) begin
            res_status = srp_pkg::ST_TABLE_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count[IDX_W-1:0];
            mem_wdata = '{cursor: w_pad, top: new_base[srp_pkg::DIM_W-1:0], height: h_pad};
            count_inc = 1'b1;
            res_y     = new_base[srp_pkg::RECT_W-1:0];
          end
        end
      end
      default: begin
        state_next = srp_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srp_pkg::FSM_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (count_clear) begin
        count <= '0;
      end else if (count_inc) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= scan_addr;
    rd_last <= scan_end;
    if (req_fire) begin
      scan_addr <= '0;
      op_clear  <= (req.cmd == srp_pkg::CMD_CLEAR);
      op_zero   <= (req.rect_width == '0) || (req.rect_height == '0);
      w_pad     <= srp_pkg::DIM_W'(req.rect_width) + srp_pkg::DIM_W'(padding);
      h_pad     <= srp_pkg::DIM_W'(req.rect_height) + srp_pkg::DIM_W'(padding);
    end else if (rd_en) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_x      <= res_x;
      out_y      <= res_y;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.pos_x  = out_x;
  assign rsp.pos_y  = out_y;

  `SRP_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_SHELVES), "shelf count over table depth")
  `SRP_ASSERT_SAME(a_fail_zero_pos, clk, rst, rsp.valid && (rsp.status != srp_pkg::ST_OK), (rsp.pos_x == '0) && (rsp.pos_y == '0), "failure response carries a position")
  `SRP_ASSERT_SAME(a_read_in_scan, clk, rst, rd_valid, (state == srp_pkg::FSM_SCAN) || (state == srp_pkg::FSM_DRAIN), "shelf read data outside scan")
  `SRP_ASSERT_NEXT(a_load_shows, clk, rst, out_load, rsp.valid && (state == srp_pkg::FSM_IDLE), "response not presented after decide")

endmodule
